// ----- src/cpid_pkg.sv -----
// Shared types, register indexes, opcodes and clamp helper for the clamped PID controller.
// No dependencies; imported by cpid_datapath and clamped_pid_controller.
package cpid_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int VALUE_W     = 16;
  localparam int LIMIT_W     = 15;

  localparam logic [CFG_INDEX_W-1:0] REG_SETPOINT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D   = 3'd4;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic signed [VALUE_W-1:0] SETPOINT_RESET = 16'sd0;
  localparam logic [LIMIT_W-1:0]        LIMIT_RESET    = 15'h7FFF;
  localparam logic signed [VALUE_W-1:0] GAIN_P_RESET   = 16'sd1;
  localparam logic signed [VALUE_W-1:0] GAIN_I_RESET   = 16'sd0;
  localparam logic signed [VALUE_W-1:0] GAIN_D_RESET   = 16'sd0;

  typedef struct packed {
    logic signed [VALUE_W-1:0] setpoint;
    logic [LIMIT_W-1:0]        limit;
    logic signed [VALUE_W-1:0] gain_p;
    logic signed [VALUE_W-1:0] gain_i;
    logic signed [VALUE_W-1:0] gain_d;
  } cpid_cfg_t;

  function automatic logic signed [VALUE_W-1:0] clamp_sym(
    input logic signed [VALUE_W:0] v,
    input logic [LIMIT_W-1:0]      bound
  );
    logic signed [VALUE_W:0] hi;
    logic signed [VALUE_W:0] lo;
    logic signed [VALUE_W:0] r;
    hi = signed'({2'b00, bound});
    lo = -hi;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return signed'(r[VALUE_W-1:0]);
  endfunction

endpackage

// ----- src/cpid_datapath.sv -----
// Combinational PID arithmetic: error, integral, derivative, weighted sum, output clamp and clear.
// Depends on cpid_pkg for the configuration struct and the clamp helper.
module cpid_datapath
  import cpid_pkg::*;
(
  input  cpid_cfg_t                 cfg,
  input  logic                      opcode,
  input  logic signed [VALUE_W-1:0] measurement,
  input  logic signed [VALUE_W-1:0] integral_sum,
  input  logic signed [VALUE_W-1:0] previous_error,
  output logic signed [VALUE_W-1:0] integral_sum_next,
  output logic signed [VALUE_W-1:0] previous_error_next,
  output logic [LIMIT_W-1:0]        drive_next
);

  localparam int PROD_W = 2 * VALUE_W;
  localparam int SUM_W  = PROD_W + 2;

  logic signed [VALUE_W:0]   err_wide;
  logic signed [VALUE_W:0]   integ_wide;
  logic signed [VALUE_W:0]   deriv_wide;
  logic signed [VALUE_W-1:0] err;
  logic signed [VALUE_W-1:0] integ;
  logic signed [VALUE_W-1:0] deriv;
  logic signed [PROD_W-1:0]  prod_p;
  logic signed [PROD_W-1:0]  prod_i;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [SUM_W-1:0]   total;
  logic signed [SUM_W-1:0]   limit_wide;
  logic [LIMIT_W-1:0]        drive_calc;

  assign err_wide   = (VALUE_W+1)'(cfg.setpoint) - (VALUE_W+1)'(measurement);
  assign err        = clamp_sym(err_wide, cfg.limit);
  assign integ_wide = (VALUE_W+1)'(integral_sum) + (VALUE_W+1)'(err);
  assign integ      = clamp_sym(integ_wide, cfg.limit);
  assign deriv_wide = (VALUE_W+1)'(err) - (VALUE_W+1)'(previous_error);
  assign deriv      = clamp_sym(deriv_wide, cfg.limit);

  assign prod_p = cfg.gain_p * err;
  assign prod_i = cfg.gain_i * integ;
  assign prod_d = cfg.gain_d * deriv;

  assign total      = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
  assign limit_wide = signed'({{(SUM_W-LIMIT_W){1'b0}}, cfg.limit});

  always_comb begin
    if (total < 0) begin
      drive_calc = '0;
    end else if (total > limit_wide) begin
      drive_calc = cfg.limit;
    end else begin
      drive_calc = total[LIMIT_W-1:0];
    end
  end

  always_comb begin
    if (opcode == OP_CLEAR) begin
      integral_sum_next   = '0;
      previous_error_next = '0;
      drive_next          = '0;
    end else begin
      integral_sum_next   = integ;
      previous_error_next = err;
      drive_next          = drive_calc;
    end
  end

endmodule

// ----- src/clamped_pid_controller.sv -----
// Top level of the clamped PID controller: input register, state, config registers, result register.
// Depends on cpid_pkg and cpid_datapath.
//
// Takes one item per clock cycle while the result register is not stalled; each item passes
// through the input register, then the result register, and one result leaves per item.
// The rate is set by the combinational datapath between the two registers, where the
// integral and previous error are read and written back in the same cycle. A clear item
// zeroes the stored state and yields drive 0. The configuration port is always ready;
// write it only while no item is in flight. No clearing pass is needed after reset.
module clamped_pid_controller
  import cpid_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      opcode,
  input  logic signed [VALUE_W-1:0] measurement,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [LIMIT_W-1:0]        drive,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [VALUE_W-1:0]        cfg_data
);

  cpid_cfg_t                 cfg;
  logic                      s1_valid;
  logic                      s1_opcode;
  logic signed [VALUE_W-1:0] s1_measurement;
  logic signed [VALUE_W-1:0] integral_sum;
  logic signed [VALUE_W-1:0] previous_error;
  logic signed [VALUE_W-1:0] integral_sum_next;
  logic signed [VALUE_W-1:0] previous_error_next;
  logic [LIMIT_W-1:0]        drive_next;
  logic                      res_open;
  logic                      advance;
  logic                      in_fire;

  assign cfg_ready = 1'b1;
  assign res_open  = !out_valid || !out_stall;
  assign advance   = s1_valid && res_open;
  assign in_stall  = s1_valid && !res_open;
  assign in_fire   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint <= SETPOINT_RESET;
      cfg.limit    <= LIMIT_RESET;
      cfg.gain_p   <= GAIN_P_RESET;
      cfg.gain_i   <= GAIN_I_RESET;
      cfg.gain_d   <= GAIN_D_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SETPOINT: cfg.setpoint <= signed'(cfg_data);
        REG_LIMIT:    cfg.limit    <= cfg_data[LIMIT_W-1:0];
        REG_GAIN_P:   cfg.gain_p   <= signed'(cfg_data);
        REG_GAIN_I:   cfg.gain_i   <= signed'(cfg_data);
        REG_GAIN_D:   cfg.gain_d   <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_opcode      <= opcode;
      s1_measurement <= measurement;
    end
  end

  cpid_datapath u_datapath (
    .cfg                 (cfg),
    .opcode              (s1_opcode),
    .measurement         (s1_measurement),
    .integral_sum        (integral_sum),
    .previous_error      (previous_error),
    .integral_sum_next   (integral_sum_next),
    .previous_error_next (previous_error_next),
    .drive_next          (drive_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum   <= '0;
      previous_error <= '0;
    end else if (advance) begin
      integral_sum   <= integral_sum_next;
      previous_error <= previous_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive <= drive_next;
    end
  end

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_opcode == OP_CLEAR) |=>
      (out_valid && drive == '0 && integral_sum == '0 && previous_error == '0))
    else $error("clear did not zero state and drive");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(integral_sum) && $stable(previous_error)))
    else $error("controller state changed without a transfer");

  a_advance_shows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result not presented after advance");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> s1_valid)
    else $error("accepted item lost from input register");

endmodule

// ----- sim/tb_top.sv -----
// Testbench for clamped_pid_controller: queued stimulus, in-line PID predictor and drive checker.
// Depends on cpid_pkg and the clamped_pid_controller RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_top;
  import cpid_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic                      op;
    logic signed [VALUE_W-1:0] meas;
  } sample_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      opcode = OP_UPDATE;
  logic signed [VALUE_W-1:0] measurement = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [LIMIT_W-1:0]        drive;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_W-1:0]    cfg_index = '0;
  logic [VALUE_W-1:0]        cfg_data = '0;

  sample_t            sample_queue[$];
  sample_t            next_sample;
  logic [LIMIT_W-1:0] drive_expect[$];
  logic [LIMIT_W-1:0] drive_want;
  int                 send_idle_pct = 32;
  int                 recv_idle_pct = 69;
  int                 mismatch_count = 0;
  int                 cycle_count = 0;

  logic signed [VALUE_W-1:0] sp_q;
  logic [LIMIT_W-1:0]        lim_q;
  logic signed [VALUE_W-1:0] kp_q;
  logic signed [VALUE_W-1:0] ki_q;
  logic signed [VALUE_W-1:0] kd_q;
  longint                    integ_acc;
  longint                    last_err;

  clamped_pid_controller dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .measurement(measurement),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .drive      (drive),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint bound_to(longint v, longint lo, longint hi);
    if (v < lo) begin
      return lo;
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  function automatic logic [LIMIT_W-1:0] pid_drive_predict(logic op,
                                                           logic signed [VALUE_W-1:0] meas);
    longint b;
    longint err;
    longint integ;
    longint deriv;
    longint sum;
    if (op == OP_CLEAR) begin
      integ_acc = 0;
      last_err  = 0;
      return '0;
    end
    b     = longint'(lim_q);
    err   = bound_to(longint'(sp_q) - longint'(meas), -b, b);
    integ = bound_to(integ_acc + err, -b, b);
    deriv = bound_to(err - last_err, -b, b);
    sum   = longint'(kp_q) * err + longint'(ki_q) * integ + longint'(kd_q) * deriv;
    sum   = bound_to(sum, 0, b);
    integ_acc = integ;
    last_err  = err;
    return LIMIT_W'(sum);
  endfunction

  // Track register writes and predict each accepted sample.
  always @(posedge clk) begin
    if (rst) begin
      sp_q      = SETPOINT_RESET;
      lim_q     = LIMIT_RESET;
      kp_q      = GAIN_P_RESET;
      ki_q      = GAIN_I_RESET;
      kd_q      = GAIN_D_RESET;
      integ_acc = 0;
      last_err  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SETPOINT: sp_q = cfg_data;
          REG_LIMIT:    lim_q = cfg_data[LIMIT_W-1:0];
          REG_GAIN_P:   kp_q = cfg_data;
          REG_GAIN_I:   ki_q = cfg_data;
          REG_GAIN_D:   kd_q = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        drive_expect.push_back(pid_drive_predict(opcode, measurement));
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_sample = sample_queue.pop_front();
        in_valid    <= 1'b1;
        opcode      <= next_sample.op;
        measurement <= next_sample.meas;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (drive_expect.size() == 0) begin
        $error("drive: unexpected transfer, actual %0d", drive);
        mismatch_count++;
      end else begin
        drive_want = drive_expect.pop_front();
        if (drive !== drive_want) begin
          $error("drive mismatch: expected %0d, actual %0d", drive_want, drive);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic push_sample(logic op, int meas);
    sample_t s;
    s.op   = op;
    s.meas = VALUE_W'(meas);
    sample_queue.push_back(s);
  endtask

  // Hold valid across back-to-back writes; the caller drops it.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [VALUE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(int sp, int lim, int kp, int ki, int kd, bit spare);
    write_reg(REG_SETPOINT, VALUE_W'(sp));
    write_reg(REG_LIMIT, VALUE_W'(lim));
    write_reg(REG_GAIN_P, VALUE_W'(kp));
    write_reg(REG_GAIN_I, VALUE_W'(ki));
    write_reg(REG_GAIN_D, VALUE_W'(kd));
    if (spare) begin
      for (int idx = REG_GAIN_D + 1; idx < (1 << CFG_INDEX_W); idx++) begin
        write_reg(CFG_INDEX_W'(idx), VALUE_W'($urandom));
      end
    end
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (sample_queue.size() != 0 || in_valid || drive_expect.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  function automatic int pick_gain();
    int r;
    r = $urandom_range(99);
    if (r < 8) begin
      return -32768;
    end else if (r < 15) begin
      return 32767;
    end else if (r < 65) begin
      return int'($urandom_range(0, 6)) - 3;
    end
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic queue_random_samples(int count);
    int r;
    int m;
    int span;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 5) begin
        push_sample(OP_CLEAR, int'($urandom_range(0, 65535)) - 32768);
      end else if (r < 20) begin
        push_sample(OP_UPDATE, int'($urandom_range(0, 65535)) - 32768);
      end else begin
        case ($urandom_range(2))
          0: span = 8;
          1: span = 300;
          default: span = 5000;
        endcase
        m = int'(sp_q) + int'($urandom_range(0, 2 * span)) - span;
        push_sample(OP_UPDATE, int'(bound_to(m, -32768, 32767)));
      end
    end
  endtask

  initial begin
    int r;
    int sp;
    int lim;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_sample(OP_UPDATE, -32768);
    push_sample(OP_UPDATE, 32767);
    push_sample(OP_UPDATE, 0);
    push_sample(OP_CLEAR, 1234);
    push_sample(OP_UPDATE, 100);
    push_sample(OP_UPDATE, -5);
    wait_drained();

    // zero limit forces every term and the drive to 0
    set_config(-32768, 0, 32767, 32767, 32767, 1'b1);
    push_sample(OP_UPDATE, 32767);
    push_sample(OP_UPDATE, -32768);
    push_sample(OP_CLEAR, -1);
    wait_drained();

    set_config(32767, 32767, 0, 1, 0, 1'b0);
    push_sample(OP_UPDATE, 12767);
    push_sample(OP_UPDATE, -32768);
    wait_drained();

    // lower the limit under a saturated integral
    set_config(32767, 100, 1, 1, -32768, 1'b0);
    push_sample(OP_UPDATE, 32767);
    push_sample(OP_UPDATE, 32700);
    push_sample(OP_UPDATE, 32767);
    wait_drained();

    set_config(0, 32767, -32768, -32768, -32768, 1'b0);
    push_sample(OP_UPDATE, 32767);
    push_sample(OP_UPDATE, -32768);
    wait_drained();

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 69;
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int ph = 0; ph < 3; ph++) begin
        r = $urandom_range(99);
        if (r < 20) begin
          sp = ($urandom_range(1) != 0) ? 32767 : -32768;
        end else begin
          sp = int'($urandom_range(0, 65535)) - 32768;
        end
        r = $urandom_range(99);
        if (r < 15) begin
          lim = 0;
        end else if (r < 30) begin
          lim = 32767;
        end else if (r < 70) begin
          lim = $urandom_range(1, 500);
        end else begin
          lim = $urandom_range(0, 32767);
        end
        set_config(sp, lim, pick_gain(), pick_gain(), pick_gain(), $urandom_range(99) < 30);
        queue_random_samples(50);
        wait_drained();
      end
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/cpid_pkg.sv
src/cpid_datapath.sv
src/clamped_pid_controller.sv
sim/tb_top.sv
